// ===== hw/rtl/hvps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hvps_pkg;

    // sequencer modes
    localparam logic [2:0] MODE_LED       = 3'd0;
    localparam logic [2:0] MODE_PRECHECK  = 3'd1;
    localparam logic [2:0] MODE_STANDBY   = 3'd2;
    localparam logic [2:0] MODE_PRECHARGE = 3'd3;
    localparam logic [2:0] MODE_HOLD      = 3'd4;
    localparam logic [2:0] MODE_ACTIVE    = 3'd5;

    // fault bits
    localparam logic [12:0] F_DIS_OPEN   = 13'h0001;
    localparam logic [12:0] F_PRE_CLOSED = 13'h0002;
    localparam logic [12:0] F_POS_CLOSED = 13'h0004;
    localparam logic [12:0] F_NEG_CLOSED = 13'h0008;
    localparam logic [12:0] F_PRECHECK_V = 13'h0010;
    localparam logic [12:0] F_WAIT_DIS   = 13'h0020;
    localparam logic [12:0] F_WAIT_ACT   = 13'h0040;
    localparam logic [12:0] F_DEACT      = 13'h0080;
    localparam logic [12:0] F_SD_OPEN    = 13'h0100;
    localparam logic [12:0] F_PRE_OPEN   = 13'h0200;
    localparam logic [12:0] F_POS_OPEN   = 13'h0400;
    localparam logic [12:0] F_NEG_OPEN   = 13'h0800;
    localparam logic [12:0] F_DEVIATION  = 13'h1000;

    // register indexes
    localparam logic [2:0] REG_TICK        = 3'd0;
    localparam logic [2:0] REG_HB_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_LED_CHECK   = 3'd2;
    localparam logic [2:0] REG_GRACE       = 3'd3;
    localparam logic [2:0] REG_HOLD        = 3'd4;
    localparam logic [2:0] REG_RESIDUAL    = 3'd5;
    localparam logic [2:0] REG_DEVIATION   = 3'd6;
    localparam logic [2:0] REG_CHARGE_DONE = 3'd7;

    // voltage conversion: volts = floor(d*97/400) = (d*VOLT_MUL) >> VOLT_SHIFT for d < 1650
    localparam logic [11:0] REF_MV     = 12'd3300;
    localparam logic [11:0] HALF_MV    = 12'd1650;
    localparam logic [21:0] VOLT_MUL   = 22'd4068475;
    localparam int          VOLT_SHIFT = 24;

    // charge curve: per-entry decay exp(-16ms/3.3s) in Q0.32
    localparam logic [31:0] DECAY_Q32  = 32'd4274193613;
    localparam int          STEP_SHIFT = 4;

    typedef struct packed {
        logic [9:0]  tick_ms;
        logic [15:0] heartbeat_timeout_ms;
        logic [15:0] led_check_ms;
        logic [15:0] fault_grace_ms;
        logic [15:0] hold_ms;
        logic [8:0]  residual_limit;
        logic [8:0]  deviation_limit;
        logic [15:0] charge_done_ms;
    } hvps_cfg_t;

    typedef struct packed {
        logic [8:0] precharge_volts;
        logic [8:0] tractive_volts;
        logic       shutdown_high;
        logic       precharge_aux_high;
        logic       air_pos_aux_high;
        logic       air_neg_aux_high;
        logic       heartbeat_seen;
    } hvps_item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] pin_word;
        logic [12:0] fault_flags;
        logic [12:0] reported_flags;
        logic [3:0]  relays_closed;
        logic [8:0]  precharge_volts;
        logic [8:0]  tractive_volts;
    } hvps_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hvps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// input request channel
interface hvps_in_if #(parameter int ADC_BITS = 12);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_precharge;
    logic [ADC_BITS-1:0] adc_tractive;
    logic                shutdown_high;
    logic                precharge_aux_high;
    logic                air_pos_aux_high;
    logic                air_neg_aux_high;
    logic                heartbeat_seen;

    modport source (
        output valid, adc_precharge, adc_tractive, shutdown_high,
        output precharge_aux_high, air_pos_aux_high, air_neg_aux_high, heartbeat_seen,
        input  ready
    );
    modport sink (
        input  valid, adc_precharge, adc_tractive, shutdown_high,
        input  precharge_aux_high, air_pos_aux_high, air_neg_aux_high, heartbeat_seen,
        output ready
    );
endinterface

// result channel
interface hvps_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] pin_word;
    logic [12:0] fault_flags;
    logic [12:0] reported_flags;
    logic [3:0]  relays_closed;
    logic [8:0]  precharge_volts;
    logic [8:0]  tractive_volts;

    modport source (
        output valid, mode, pin_word, fault_flags, reported_flags,
        output relays_closed, precharge_volts, tractive_volts,
        input  ready
    );
    modport sink (
        input  valid, mode, pin_word, fault_flags, reported_flags,
        input  relays_closed, precharge_volts, tractive_volts,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/hvps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hvps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hvps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hvps_queue
    import hvps_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire hvps_item_t wdata,
    output logic            full,
    input  wire logic       pop,
    output hvps_item_t      rdata,
    output logic            empty
);

    hvps_item_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hvps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hvps_front
    import hvps_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                enable,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ADC_BITS-1:0] adc_precharge,
    input  wire logic [ADC_BITS-1:0] adc_tractive,
    input  wire logic                shutdown_high,
    input  wire logic                precharge_aux_high,
    input  wire logic                air_pos_aux_high,
    input  wire logic                air_neg_aux_high,
    input  wire logic                heartbeat_seen,
    output logic                     push,
    output hvps_item_t               item,
    input  wire logic                q_full
);

    localparam int PW = ADC_BITS + 12;

    logic             s1_valid_reg, s2_valid_reg;
    logic [11:0]      s_pre_reg, s_trac_reg;
    logic [4:0]       bits_reg;
    hvps_item_t       item_reg;
    logic [PW-1:0]    mv_pre, mv_trac;
    logic [10:0]      d_pre, d_trac;
    logic [32:0]      v_pre, v_trac;
    logic             accept;

    assign in_ready = enable && !s1_valid_reg && !s2_valid_reg;
    assign accept   = in_valid && in_ready;
    assign push     = s2_valid_reg && !q_full;
    assign item     = item_reg;

    // counts to millivolts
    assign mv_pre  = PW'(REF_MV) * PW'(adc_precharge);
    assign mv_trac = PW'(REF_MV) * PW'(adc_tractive);

    // millivolts above mid-rail to volts
    assign d_pre  = (s_pre_reg  > HALF_MV) ? 11'(s_pre_reg  - HALF_MV) : 11'd0;
    assign d_trac = (s_trac_reg > HALF_MV) ? 11'(s_trac_reg - HALF_MV) : 11'd0;
    assign v_pre  = 33'(d_pre)  * 33'(VOLT_MUL);
    assign v_trac = 33'(d_trac) * 33'(VOLT_MUL);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_pre_reg  <= 12'(mv_pre  >> ADC_BITS);
            s_trac_reg <= 12'(mv_trac >> ADC_BITS);
            bits_reg   <= {shutdown_high, precharge_aux_high, air_pos_aux_high,
                           air_neg_aux_high, heartbeat_seen};
        end
        if (s1_valid_reg)
        begin
            item_reg.precharge_volts    <= 9'(v_pre  >> VOLT_SHIFT);
            item_reg.tractive_volts     <= 9'(v_trac >> VOLT_SHIFT);
            item_reg.shutdown_high      <= bits_reg[4];
            item_reg.precharge_aux_high <= bits_reg[3];
            item_reg.air_pos_aux_high   <= bits_reg[2];
            item_reg.air_neg_aux_high   <= bits_reg[1];
            item_reg.heartbeat_seen     <= bits_reg[0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hvps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hvps_back
    import hvps_pkg::*;
#(
    parameter int CURVE_DEPTH = 1024
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire hvps_cfg_t  cfg,
    output logic            ready_for_items,
    input  wire logic       q_empty,
    input  wire hvps_item_t q_data,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output hvps_result_t    out_data
);

    localparam int AW = $clog2(CURVE_DEPTH);

    localparam logic [2:0] ST_FILL = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_AGE  = 3'd2;
    localparam logic [2:0] ST_RDA  = 3'd3;
    localparam logic [2:0] ST_RDB  = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_DEC  = 3'd6;

    logic [2:0]   state_reg, state_next;
    logic [2:0]   mode_reg;
    logic [15:0]  time_reg;
    logic [15:0]  age_reg;
    logic [12:0]  latch_reg;
    logic         alive_reg;
    hvps_item_t   item_reg;
    logic [15:0]  a_reg;
    logic [15:0]  factor_reg;
    logic [8:0]   exp_reg;
    logic [AW-1:0] fill_cnt_reg;
    logic [32:0]  e_reg;
    logic         out_valid_reg;
    hvps_result_t result_reg;

    // curve fill
    logic [33:0]  c_sum;
    logic [15:0]  c_val;
    logic [63:0]  e_prod;
    logic [32:0]  e_next;

    // curve lookup
    logic [11:0]  idx;
    logic [3:0]   frac;
    logic [12:0]  idx_p1;
    logic         in_range;
    logic [AW-1:0] raddr;
    logic [15:0]  rdata;
    logic [15:0]  b_fix;
    logic [19:0]  slope_prod;
    logic [15:0]  factor_calc;
    logic [24:0]  exp_prod;

    // step decision
    logic [16:0]  age_sum;
    logic [15:0]  age_next;
    logic [8:0]   dev;
    logic [12:0]  f;
    logic [2:0]   nm;
    logic         changed;
    logic [16:0]  time_sum;
    logic [15:0]  time_next;
    logic [12:0]  latch_next;
    logic         sd, pre_open, pos_open, neg_open;
    logic         step_done;

    function automatic logic [15:0] make_pins(input logic [2:0] m, input logic [12:0] ff);
        logic [15:0] p;
        p = '0;
        if (m == MODE_PRECHECK || m == MODE_LED) p[11] = 1'b1;
        if (m == MODE_STANDBY || m == MODE_LED) p[10] = 1'b1;
        if (m == MODE_PRECHARGE || m == MODE_HOLD || m == MODE_LED) p[1] = 1'b1;
        if (m == MODE_ACTIVE || m == MODE_HOLD || m == MODE_LED) p[0] = 1'b1;
        if (m == MODE_LED) p[15:12] = 4'hf;
        if (m == MODE_LED) p[4] = 1'b1;
        if (m == MODE_PRECHARGE || m == MODE_HOLD || m == MODE_ACTIVE) p[7:6] = 2'b11;
        if (m == MODE_HOLD || m == MODE_ACTIVE) p[5] = 1'b1;
        if (m == MODE_PRECHARGE || m == MODE_HOLD) p[2] = 1'b1;
        if ((ff & F_WAIT_DIS) != '0) p[4] = 1'b1;
        if ((ff & (F_PRE_CLOSED | F_PRE_OPEN)) != '0) p[13] = 1'b1;
        if ((ff & (F_POS_CLOSED | F_POS_OPEN)) != '0) p[14] = 1'b1;
        if ((ff & (F_NEG_CLOSED | F_NEG_OPEN)) != '0) p[15] = 1'b1;
        return p & 16'hfcf7;
    endfunction

    assign ready_for_items = (state_reg != ST_FILL);
    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    // curve entry from the running decay e, then the next decay
    assign c_sum  = 34'h1_0000_0000 - {1'b0, e_reg} + 34'd32768;
    assign c_val  = (c_sum[33:32] != 2'b00) ? 16'hffff : c_sum[31:16];
    assign e_prod = 64'(e_reg[31:0]) * 64'(DECAY_Q32);
    assign e_next = e_reg[32] ? 33'(DECAY_Q32) : 33'((e_prod + 64'h8000_0000) >> 32);

    hvps_ram #(
        .WIDTH (16),
        .DEPTH (CURVE_DEPTH)
    ) u_curve (
        .clk   (clk),
        .we    (state_reg == ST_FILL),
        .waddr (fill_cnt_reg),
        .wdata (c_val),
        .raddr (raddr),
        .rdata (rdata)
    );

    // curve addresses: entry then its neighbor
    assign idx      = time_reg[15:STEP_SHIFT];
    assign frac     = time_reg[STEP_SHIFT-1:0];
    assign idx_p1   = 13'(idx) + 13'd1;
    assign in_range = idx_p1 < 13'(CURVE_DEPTH);
    assign raddr    = (state_reg == ST_RDA) ? idx_p1[AW-1:0] : idx[AW-1:0];

    // interpolation and expected volts
    assign b_fix       = (rdata < a_reg) ? a_reg : rdata;
    assign slope_prod  = 20'(b_fix - a_reg) * 20'(frac);
    assign factor_calc = a_reg + 16'(slope_prod >> STEP_SHIFT);
    assign exp_prod    = 25'(item_reg.precharge_volts) * 25'(factor_reg);

    // heartbeat aging
    assign age_sum  = 17'(age_reg) + 17'(cfg.tick_ms);
    assign age_next = item_reg.heartbeat_seen ? 16'd0 :
                      (age_sum[16] ? 16'hffff : age_sum[15:0]);

    assign sd       = item_reg.shutdown_high;
    assign pre_open = item_reg.precharge_aux_high;
    assign pos_open = item_reg.air_pos_aux_high;
    assign neg_open = item_reg.air_neg_aux_high;
    assign dev      = (exp_reg > item_reg.tractive_volts) ?
                      exp_reg - item_reg.tractive_volts : item_reg.tractive_volts - exp_reg;

    // fault classification and next mode
    always_comb
    begin
        f  = '0;
        nm = mode_reg;
        unique case (mode_reg)
            MODE_LED:
            begin
                nm = (time_reg > cfg.led_check_ms) ? MODE_PRECHECK : MODE_LED;
            end
            MODE_PRECHARGE:
            begin
                if (!alive_reg) f |= F_DEACT;
                if (!sd) f |= F_SD_OPEN;
                if (pre_open) f |= F_PRE_OPEN;
                if (!pos_open) f |= F_POS_CLOSED;
                if (neg_open) f |= F_NEG_OPEN;
                if (f != '0)
                begin
                    nm = (!alive_reg || time_reg > cfg.fault_grace_ms) ?
                         MODE_PRECHECK : MODE_PRECHARGE;
                end
                else if (dev > cfg.deviation_limit)
                begin
                    f  = F_DEVIATION;
                    nm = (time_reg > cfg.fault_grace_ms) ? MODE_PRECHECK : MODE_PRECHARGE;
                end
                else
                begin
                    nm = (time_reg > cfg.charge_done_ms) ? MODE_HOLD : MODE_PRECHARGE;
                end
            end
            MODE_HOLD:
            begin
                if (!alive_reg) f |= F_DEACT;
                if (!sd) f |= F_SD_OPEN;
                if (pre_open) f |= F_PRE_OPEN;
                if (pos_open) f |= F_POS_OPEN;
                if (neg_open) f |= F_NEG_OPEN;
                if (f != '0)
                begin
                    nm = (!alive_reg || time_reg > cfg.fault_grace_ms) ?
                         MODE_PRECHECK : MODE_HOLD;
                end
                else
                begin
                    nm = (time_reg >= cfg.hold_ms) ? MODE_ACTIVE : MODE_HOLD;
                end
            end
            MODE_ACTIVE:
            begin
                if (!alive_reg) f |= F_DEACT;
                if (!sd) f |= F_SD_OPEN;
                if (!pre_open) f |= F_PRE_CLOSED;
                if (pos_open) f |= F_POS_OPEN;
                if (neg_open) f |= F_NEG_OPEN;
                nm = (f != '0) ? MODE_PRECHECK : MODE_ACTIVE;
            end
            default:
            begin
                // precheck, standby and unused codes
                if (sd) f |= F_DIS_OPEN;
                if (!pre_open) f |= F_PRE_CLOSED;
                if (!pos_open) f |= F_POS_CLOSED;
                if (!neg_open) f |= F_NEG_CLOSED;
                if (item_reg.precharge_volts > cfg.residual_limit) f |= F_PRECHECK_V;
                if (item_reg.tractive_volts > cfg.residual_limit) f |= F_WAIT_DIS;
                if (f != '0)
                begin
                    nm = MODE_PRECHECK;
                end
                else if (!alive_reg)
                begin
                    nm = MODE_STANDBY;
                    f  = F_WAIT_ACT;
                end
                else
                begin
                    nm = MODE_PRECHARGE;
                end
            end
        endcase
    end

    // time in mode and fault latch
    assign changed    = (nm != mode_reg);
    assign time_sum   = 17'(time_reg) + 17'(cfg.tick_ms);
    assign time_next  = changed ? 16'(cfg.tick_ms) :
                        (time_sum[16] ? 16'hffff : time_sum[15:0]);
    assign latch_next = (changed && !(mode_reg inside {MODE_PRECHECK, MODE_STANDBY})) ?
                        f : latch_reg;
    assign step_done  = (state_reg == ST_DEC) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL: if (fill_cnt_reg == AW'(CURVE_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: if (!q_empty) state_next = ST_AGE;
            ST_AGE:  state_next = ST_RDA;
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DEC;
            ST_DEC:  if (step_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_cnt_reg  <= '0;
            e_reg         <= 33'h1_0000_0000;
            mode_reg      <= MODE_LED;
            time_reg      <= '0;
            age_reg       <= 16'hffff;
            latch_reg     <= '0;
            alive_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FILL)
            begin
                fill_cnt_reg <= fill_cnt_reg + AW'(1);
                e_reg        <= e_next;
            end
            if (state_reg == ST_AGE)
            begin
                age_reg   <= age_next;
                alive_reg <= (age_next <= cfg.heartbeat_timeout_ms);
            end
            if (step_done)
            begin
                mode_reg  <= nm;
                time_reg  <= time_next;
                latch_reg <= latch_next;
            end
            if (step_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_data;
        end
        if (state_reg == ST_RDA)
        begin
            a_reg <= rdata;
        end
        if (state_reg == ST_RDB)
        begin
            factor_reg <= in_range ? factor_calc : 16'hffff;
        end
        if (state_reg == ST_MUL)
        begin
            exp_reg <= 9'(exp_prod >> 16);
        end
        if (step_done)
        begin
            result_reg.mode            <= nm;
            result_reg.pin_word        <= make_pins(nm, f);
            result_reg.fault_flags     <= f;
            result_reg.reported_flags  <= f | latch_next;
            result_reg.relays_closed   <= {!neg_open, !pos_open, !pre_open, !sd};
            result_reg.precharge_volts <= item_reg.precharge_volts;
            result_reg.tractive_volts  <= item_reg.tractive_volts;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hv_precharge_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Precharge sequencer for a high-voltage tractive system. Each request is one
// periodic tick: two raw converter counts, four sense pins and a heartbeat flag.
// The front end converts counts to volts, taking no new request until the last
// is pushed, and hands the request through a two-entry queue to the sequencer,
// which ages the heartbeat, reads two neighboring entries of the 1 - exp(-t/3.3 s)
// charge curve through the single read port of the curve RAM, scales and
// compares, and steps the six-mode state machine. From queue to result register
// it passes aging, the two curve reads, the expected-voltage multiply and the
// decision. After reset the curve RAM is filled, one entry a cycle, with all
// CURVE_DEPTH entries; no request is taken until then, while register writes are
// accepted at any time over the APB port (registers at 4*index).

module hv_precharge_sequencer
    import hvps_pkg::*;
#(
    parameter int CURVE_DEPTH = 1024,
    parameter int ADC_BITS    = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    hvps_in_if.sink          in_ch,
    hvps_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    hvps_cfg_t    cfg_reg;
    logic [2:0]   reg_idx;
    logic         cfg_write;
    logic         back_ready;
    logic         q_push, q_full, q_pop, q_empty;
    hvps_item_t   q_wdata, q_rdata;
    hvps_result_t result;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_ms              <= 10'd10;
            cfg_reg.heartbeat_timeout_ms <= 16'd250;
            cfg_reg.led_check_ms         <= 16'd500;
            cfg_reg.fault_grace_ms       <= 16'd500;
            cfg_reg.hold_ms              <= 16'd500;
            cfg_reg.residual_limit       <= 9'd5;
            cfg_reg.deviation_limit      <= 9'd10;
            cfg_reg.charge_done_ms       <= 16'd9900;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_TICK:        cfg_reg.tick_ms              <= pwdata[9:0];
                REG_HB_TIMEOUT:  cfg_reg.heartbeat_timeout_ms <= pwdata[15:0];
                REG_LED_CHECK:   cfg_reg.led_check_ms         <= pwdata[15:0];
                REG_GRACE:       cfg_reg.fault_grace_ms       <= pwdata[15:0];
                REG_HOLD:        cfg_reg.hold_ms              <= pwdata[15:0];
                REG_RESIDUAL:    cfg_reg.residual_limit       <= pwdata[8:0];
                REG_DEVIATION:   cfg_reg.deviation_limit      <= pwdata[8:0];
                REG_CHARGE_DONE: cfg_reg.charge_done_ms       <= pwdata[15:0];
                default:         cfg_reg.tick_ms              <= cfg_reg.tick_ms;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_idx)
            REG_TICK:        prdata = 32'(cfg_reg.tick_ms);
            REG_HB_TIMEOUT:  prdata = 32'(cfg_reg.heartbeat_timeout_ms);
            REG_LED_CHECK:   prdata = 32'(cfg_reg.led_check_ms);
            REG_GRACE:       prdata = 32'(cfg_reg.fault_grace_ms);
            REG_HOLD:        prdata = 32'(cfg_reg.hold_ms);
            REG_RESIDUAL:    prdata = 32'(cfg_reg.residual_limit);
            REG_DEVIATION:   prdata = 32'(cfg_reg.deviation_limit);
            REG_CHARGE_DONE: prdata = 32'(cfg_reg.charge_done_ms);
            default:         prdata = '0;
        endcase
    end

    hvps_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .enable             (back_ready),
        .in_valid           (in_ch.valid),
        .in_ready           (in_ch.ready),
        .adc_precharge      (in_ch.adc_precharge),
        .adc_tractive       (in_ch.adc_tractive),
        .shutdown_high      (in_ch.shutdown_high),
        .precharge_aux_high (in_ch.precharge_aux_high),
        .air_pos_aux_high   (in_ch.air_pos_aux_high),
        .air_neg_aux_high   (in_ch.air_neg_aux_high),
        .heartbeat_seen     (in_ch.heartbeat_seen),
        .push               (q_push),
        .item               (q_wdata),
        .q_full             (q_full)
    );

    hvps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    hvps_back #(
        .CURVE_DEPTH (CURVE_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .ready_for_items (back_ready),
        .q_empty         (q_empty),
        .q_data          (q_rdata),
        .pop             (q_pop),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_data        (result)
    );

    // result channel payload
    assign out_ch.mode            = result.mode;
    assign out_ch.pin_word        = result.pin_word;
    assign out_ch.fault_flags     = result.fault_flags;
    assign out_ch.reported_flags  = result.reported_flags;
    assign out_ch.relays_closed   = result.relays_closed;
    assign out_ch.precharge_volts = result.precharge_volts;
    assign out_ch.tractive_volts  = result.tractive_volts;

endmodule

`default_nettype wire

// ===== sim/tb_hv_precharge_sequencer.sv =====
`timescale 1ns / 1ps

module tb_hv_precharge_sequencer;
    import hvps_pkg::*;

    // tracks sequencer state and holds the results still owed by the block
    class tick_scoreboard;
        int unsigned tick_ms, hb_timeout, lamp_ms, grace, hold_time;
        int unsigned residual, deviation, charge_done;
        int unsigned mode, elapsed, hb_age, latched;
        int unsigned errors;
        logic [15:0] charge_curve[1024];
        hvps_result_t pending[$];

        function new();
            longint unsigned e, c;
            e = 64'd1 << 32;
            for (int k = 0; k < 1024; k++)
            begin
                c = ((64'd1 << 32) - e + 64'd32768) >> 16;
                charge_curve[k] = (c > 65535) ? 16'hffff : c[15:0];
                e = (e * longint'(DECAY_Q32) + (64'd1 << 31)) >> 32;
            end
            tick_ms = 10; hb_timeout = 250; lamp_ms = 500; grace = 500;
            hold_time = 500; residual = 5; deviation = 10; charge_done = 9900;
            mode = MODE_LED; elapsed = 0; hb_age = 65535; latched = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, int unsigned v);
            case (idx)
                REG_TICK:        tick_ms = v & 10'h3ff;
                REG_HB_TIMEOUT:  hb_timeout = v & 16'hffff;
                REG_LED_CHECK:   lamp_ms = v & 16'hffff;
                REG_GRACE:       grace = v & 16'hffff;
                REG_HOLD:        hold_time = v & 16'hffff;
                REG_RESIDUAL:    residual = v & 9'h1ff;
                REG_DEVIATION:   deviation = v & 9'h1ff;
                REG_CHARGE_DONE: charge_done = v & 16'hffff;
                default: ;
            endcase
        endfunction

        function int unsigned count_to_volts(logic [11:0] cnt);
            int unsigned s;
            s = (3300 * cnt) >> 12;
            if (s < 1650)
                s = 1650;
            return (s - 1650) * 97 / 400;
        endfunction

        function int unsigned curve_factor(int unsigned el);
            int unsigned idx, frac, a, b;
            idx = el >> 4;
            frac = el & 15;
            if (idx + 1 >= 1024)
                return 65535;
            a = charge_curve[idx];
            b = charge_curve[idx + 1];
            if (b < a)
                b = a;
            return a + (((b - a) * frac) >> 4);
        endfunction

        function int unsigned sat_add(int unsigned a, int unsigned b);
            return (a + b > 65535) ? 65535 : a + b;
        endfunction

        // one accepted tick request: step the sequencer and queue its result
        function void note_request(logic [11:0] adc_p, logic [11:0] adc_t,
                                   logic sd, logic pre_open, logic pos_open,
                                   logic neg_open, logic hb);
            int unsigned pv, tv, f, nm, pins, relays, el, ev, dev;
            bit alive;
            hvps_result_t r;
            pv = count_to_volts(adc_p);
            tv = count_to_volts(adc_t);
            el = elapsed;
            f = 0;
            nm = mode;
            pins = 0;
            relays = 0;
            hb_age = hb ? 0 : sat_add(hb_age, tick_ms);
            alive = hb_age <= hb_timeout;
            case (mode)
                MODE_LED: nm = (el > lamp_ms) ? MODE_PRECHECK : MODE_LED;
                MODE_PRECHARGE:
                begin
                    if (!alive) f |= F_DEACT;
                    if (!sd) f |= F_SD_OPEN;
                    if (pre_open) f |= F_PRE_OPEN;
                    if (!pos_open) f |= F_POS_CLOSED;
                    if (neg_open) f |= F_NEG_OPEN;
                    if (f != 0)
                        nm = ((f & F_DEACT) || el > grace) ? MODE_PRECHECK : MODE_PRECHARGE;
                    else
                    begin
                        ev = (pv * curve_factor(el)) >> 16;
                        dev = (ev > tv) ? ev - tv : tv - ev;
                        if (dev > deviation)
                        begin
                            f = F_DEVIATION;
                            nm = (el > grace) ? MODE_PRECHECK : MODE_PRECHARGE;
                        end
                        else
                            nm = (el > charge_done) ? MODE_HOLD : MODE_PRECHARGE;
                    end
                end
                MODE_HOLD:
                begin
                    if (!alive) f |= F_DEACT;
                    if (!sd) f |= F_SD_OPEN;
                    if (pre_open) f |= F_PRE_OPEN;
                    if (pos_open) f |= F_POS_OPEN;
                    if (neg_open) f |= F_NEG_OPEN;
                    if (f != 0)
                        nm = ((f & F_DEACT) || el > grace) ? MODE_PRECHECK : MODE_HOLD;
                    else
                        nm = (el >= hold_time) ? MODE_ACTIVE : MODE_HOLD;
                end
                MODE_ACTIVE:
                begin
                    if (!alive) f |= F_DEACT;
                    if (!sd) f |= F_SD_OPEN;
                    if (!pre_open) f |= F_PRE_CLOSED;
                    if (pos_open) f |= F_POS_OPEN;
                    if (neg_open) f |= F_NEG_OPEN;
                    nm = (f != 0) ? MODE_PRECHECK : MODE_ACTIVE;
                end
                default:
                begin
                    if (sd) f |= F_DIS_OPEN;
                    if (!pre_open) f |= F_PRE_CLOSED;
                    if (!pos_open) f |= F_POS_CLOSED;
                    if (!neg_open) f |= F_NEG_CLOSED;
                    if (pv > residual) f |= F_PRECHECK_V;
                    if (tv > residual) f |= F_WAIT_DIS;
                    if (f != 0)
                        nm = MODE_PRECHECK;
                    else if (!alive)
                    begin
                        nm = MODE_STANDBY;
                        f = F_WAIT_ACT;
                    end
                    else
                        nm = MODE_PRECHARGE;
                end
            endcase

            // latch faults when leaving a working mode
            if (nm != mode)
            begin
                if (mode != MODE_PRECHECK && mode != MODE_STANDBY)
                    latched = f;
                mode = nm;
                elapsed = tick_ms;
            end
            else
                elapsed = sat_add(elapsed, tick_ms);

            // relay command and led pins
            if (mode == MODE_PRECHECK || mode == MODE_LED) pins |= 1 << 11;
            if (mode == MODE_STANDBY || mode == MODE_LED) pins |= 1 << 10;
            if (mode == MODE_PRECHARGE || mode == MODE_HOLD || mode == MODE_LED) pins |= 1 << 1;
            if (mode == MODE_ACTIVE || mode == MODE_HOLD || mode == MODE_LED) pins |= 1 << 0;
            if (mode == MODE_LED) pins |= 16'hf010;
            if (mode == MODE_PRECHARGE || mode == MODE_HOLD || mode == MODE_ACTIVE)
                pins |= 16'h00c0;
            if (mode == MODE_HOLD || mode == MODE_ACTIVE) pins |= 1 << 5;
            if (mode == MODE_PRECHARGE || mode == MODE_HOLD) pins |= 1 << 2;
            if (f & F_WAIT_DIS) pins |= 1 << 4;
            if (f & (F_PRE_CLOSED | F_PRE_OPEN)) pins |= 1 << 13;
            if (f & (F_POS_CLOSED | F_POS_OPEN)) pins |= 1 << 14;
            if (f & (F_NEG_CLOSED | F_NEG_OPEN)) pins |= 1 << 15;

            if (!sd) relays |= 1;
            if (!pre_open) relays |= 2;
            if (!pos_open) relays |= 4;
            if (!neg_open) relays |= 8;

            r.mode = mode[2:0];
            r.pin_word = pins[15:0] & 16'hfcf7;
            r.fault_flags = f[12:0];
            r.reported_flags = f[12:0] | latched[12:0];
            r.relays_closed = relays[3:0];
            r.precharge_volts = pv[8:0];
            r.tractive_volts = tv[8:0];
            pending.push_back(r);
        endfunction

        function void check_result(hvps_result_t got);
            hvps_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.mode !== want.mode)
                $display("%0t mode exp %0d got %0d", $time, want.mode, got.mode);
            if (got.pin_word !== want.pin_word)
                $display("%0t pin_word exp %h got %h", $time, want.pin_word, got.pin_word);
            if (got.fault_flags !== want.fault_flags)
                $display("%0t fault_flags exp %h got %h", $time, want.fault_flags,
                         got.fault_flags);
            if (got.reported_flags !== want.reported_flags)
                $display("%0t reported_flags exp %h got %h", $time, want.reported_flags,
                         got.reported_flags);
            if (got.relays_closed !== want.relays_closed)
                $display("%0t relays_closed exp %h got %h", $time, want.relays_closed,
                         got.relays_closed);
            if (got.precharge_volts !== want.precharge_volts)
                $display("%0t precharge_volts exp %0d got %0d", $time, want.precharge_volts,
                         got.precharge_volts);
            if (got.tractive_volts !== want.tractive_volts)
                $display("%0t tractive_volts exp %0d got %0d", $time, want.tractive_volts,
                         got.tractive_volts);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    bit quiet = 0;
    tick_scoreboard sb;

    hvps_in_if #(.ADC_BITS(12)) in_ch ();
    hvps_out_if out_ch ();

    hv_precharge_sequencer dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.adc_precharge = 0;
        in_ch.adc_tractive = 0;
        in_ch.shutdown_high = 0;
        in_ch.precharge_aux_high = 0;
        in_ch.air_pos_aux_high = 0;
        in_ch.air_neg_aux_high = 0;
        in_ch.heartbeat_seen = 0;
        out_ch.ready = 0;
    end

    // result side stalls
    always @(posedge clk)
        out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 37);

    // result monitor
    always @(posedge clk)
    begin
        hvps_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.mode = out_ch.mode;
            got.pin_word = out_ch.pin_word;
            got.fault_flags = out_ch.fault_flags;
            got.reported_flags = out_ch.reported_flags;
            got.relays_closed = out_ch.relays_closed;
            got.precharge_volts = out_ch.precharge_volts;
            got.tractive_volts = out_ch.tractive_volts;
            sb.check_result(got);
        end
    end

    task automatic reg_write(logic [2:0] idx, int unsigned v);
        @(posedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic send_tick(logic [11:0] ap, logic [11:0] at, logic sd, logic pre,
                             logic pos, logic neg, logic hb);
        if (!quiet && $urandom_range(99) < 37)
        begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.adc_precharge <= ap;
        in_ch.adc_tractive <= at;
        in_ch.shutdown_high <= sd;
        in_ch.precharge_aux_high <= pre;
        in_ch.air_pos_aux_high <= pos;
        in_ch.air_neg_aux_high <= neg;
        in_ch.heartbeat_seen <= hb;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(ap, at, sd, pre, pos, neg, hb);
    endtask

    // lowest count from mid-scale up that reads at least the given volts
    function automatic logic [11:0] count_for(int unsigned v);
        for (int c = 2048; c < 4096; c++)
            if (sb.count_to_volts(c) >= v)
                return c;
        return 12'hfff;
    endfunction

    // mostly sequences that walk the modes, some noise
    task automatic send_walk();
        logic [11:0] ap, at;
        int unsigned pv, ev;
        logic hb;
        if ($urandom_range(99) < 12)
        begin
            send_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            return;
        end
        hb = ($urandom_range(99) < 92);
        case (sb.mode)
            MODE_PRECHARGE:
            begin
                ap = $urandom_range(2048, 4095);
                pv = sb.count_to_volts(ap);
                ev = (pv * sb.curve_factor(sb.elapsed)) >> 16;
                ev = ev + $urandom_range(0, 2);
                at = (ev == 0) ? $urandom_range(0, 2047) : count_for(ev);
                send_tick(ap, at, 1, 0, 1, 0, hb);
            end
            MODE_HOLD:
                send_tick($urandom, $urandom, 1, 0, 0, 0, hb);
            MODE_ACTIVE:
                send_tick($urandom, $urandom, 1, 1, 0, 0, hb);
            default:
                send_tick($urandom_range(0, 2100), $urandom_range(0, 2100), 0, 1, 1, 1, hb);
        endcase
    endtask

    task automatic wait_drained();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        #4000000;
        $display("hv_precharge_sequencer: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned r[8];
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // directed: field extremes in led check, then fault pin patterns from precheck
        send_tick(12'h000, 12'hfff, 0, 0, 0, 0, 0);
        send_tick(12'hfff, 12'h000, 1, 1, 1, 1, 1);
        send_tick(12'h800, 12'h7ff, 1, 0, 1, 0, 1);
        send_tick(12'h7ff, 12'h801, 0, 1, 0, 1, 0);
        wait_drained();
        reg_write(REG_LED_CHECK, 0);
        send_tick(0, 0, 0, 1, 1, 1, 1);
        send_tick(0, 0, 1, 0, 0, 0, 1);
        send_tick(12'hfff, 12'hfff, 0, 1, 1, 1, 1);
        send_tick(0, 0, 0, 1, 1, 1, 0);
        send_tick(0, 0, 0, 1, 1, 1, 0);
        send_tick(0, 0, 0, 1, 1, 1, 1);
        for (int i = 0; i < 10; i++)
            send_walk();

        // configuration phases, extremes first
        for (int p = 0; p < 12; p++)
        begin
            wait_drained();
            case (p)
                0: r = '{1, 0, 0, 0, 0, 0, 0, 0};
                1: r = '{1000, 65535, 65535, 65535, 65535, 399, 399, 65535};
                default:
                    r = '{$urandom_range(1, 60), $urandom_range(0, 300), $urandom_range(0, 200),
                          $urandom_range(0, 300), $urandom_range(0, 200), $urandom_range(0, 20),
                          $urandom_range(3, 30), $urandom_range(0, 600)};
            endcase
            reg_write(REG_TICK, r[0]);
            reg_write(REG_HB_TIMEOUT, r[1]);
            reg_write(REG_LED_CHECK, r[2]);
            reg_write(REG_GRACE, r[3]);
            reg_write(REG_HOLD, r[4]);
            reg_write(REG_RESIDUAL, r[5]);
            reg_write(REG_DEVIATION, r[6]);
            reg_write(REG_CHARGE_DONE, r[7]);
            quiet = (p == 5);
            for (int i = 0; i < 120; i++)
                send_walk();
            quiet = 0;
        end

        in_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("hv_precharge_sequencer: match");
        else
            $display("hv_precharge_sequencer: mismatch");
        $finish;
    end

endmodule
